// ===== rtl/spbe_pkg.sv =====
// Package for the spectral peak / band energy block: payload, config and snapshot types.
// No dependencies; used by every module of the block.
`default_nettype none
package spbe_pkg;

  localparam int LevelBits = 24;
  localparam int BinBits   = 11;
  localparam int SumBits   = 59;
  localparam int RootBits  = 30;
  localparam int OffBits   = 16;
  localparam int NumBands  = 3;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 24;
  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};
  localparam logic [OffBits-1:0] HalfBin = 16'd16384;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegStart  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegMinLvl = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegALow   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegAHigh  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegBLow   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegBHigh  = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegCLow   = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegCHigh  = 3'd7;

  typedef struct packed {
    logic [LevelBits-1:0] magnitude;
    logic                 last_bin;
  } in_item_t;

  typedef struct packed {
    logic [BinBits-1:0]        peak_index;
    logic signed [OffBits-1:0] peak_offset;
    logic                      peak_valid;
    logic [RootBits-1:0]       band_a_energy;
    logic [RootBits-1:0]       band_b_energy;
    logic [RootBits-1:0]       band_c_energy;
  } out_item_t;

  typedef struct packed {
    logic [BinBits-1:0]                 search_start_bin;
    logic [LevelBits-1:0]               min_peak_level;
    logic [NumBands-1:0][BinBits-1:0]   band_low;
    logic [NumBands-1:0][BinBits-1:0]   band_high;
  } cfg_t;

  // End-of-spectrum snapshot handed from front to back
  typedef struct packed {
    logic [BinBits-1:0]               peak_index;
    logic                             peak_valid;
    logic                             do_offset;
    logic [LevelBits-1:0]             left_level;
    logic [LevelBits-1:0]             best_level;
    logic [LevelBits-1:0]             right_level;
    logic [NumBands-1:0][SumBits-1:0] sums;
  } snap_t;

endpackage
`default_nettype wire

// ===== rtl/spectral_peak_band_energy_top.sv =====
// The front takes one bin per cycle while the two-entry queue has room and queues a
// snapshot on the last bin. The back runs the offset divide when the peak needs an
// offset (stopping early when the offset saturates), then the three square roots,
// which always run. It does not take a new snapshot until the previous result has
// been loaded into the output register, so an output stall holds it. Reset (rst_n low,
// synchronous) loads default config and clears per-spectrum state, queue and output.
`default_nettype none
module spectral_peak_band_energy_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire spbe_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output spbe_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [spbe_pkg::CfgIdxBits-1:0]    cfg_index,
  input  wire logic [spbe_pkg::CfgDataBits-1:0]   cfg_data
);

  spbe_pkg::cfg_t  cfg_r;
  spbe_pkg::snap_t push_data, pop_data;
  logic            push, pop, full, empty;

  // config register file; writes take effect at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.search_start_bin <= 11'd9;
      cfg_r.min_peak_level   <= 24'd16777;
      cfg_r.band_low         <= {3{11'd1}};
      cfg_r.band_high        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spbe_pkg::RegStart:  cfg_r.search_start_bin <= cfg_data[10:0];
        spbe_pkg::RegMinLvl: cfg_r.min_peak_level   <= cfg_data;
        spbe_pkg::RegALow:   cfg_r.band_low[0]      <= cfg_data[10:0];
        spbe_pkg::RegAHigh:  cfg_r.band_high[0]     <= cfg_data[10:0];
        spbe_pkg::RegBLow:   cfg_r.band_low[1]      <= cfg_data[10:0];
        spbe_pkg::RegBHigh:  cfg_r.band_high[1]     <= cfg_data[10:0];
        spbe_pkg::RegCLow:   cfg_r.band_low[2]      <= cfg_data[10:0];
        spbe_pkg::RegCHigh:  cfg_r.band_high[2]     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // front: streaming peak search and band sums
  spbe_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_full(full), .q_push(push), .q_data(push_data)
  );

  // short queue of end-of-spectrum snapshots
  spbe_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .full(full), .empty(empty), .pop_data(pop_data)
  );

  // back: divide, square roots, output register
  spbe_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_pop(pop), .q_data(pop_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // an invalid peak never carries an offset
  a_invalid_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.peak_valid |-> out_data.peak_offset == '0)
    else $error("offset on invalid peak");

  // offset stays within half a bin
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.peak_offset) <= 16'sd16384 &&
                   $signed(out_data.peak_offset) >= -16'sd16384))
    else $error("offset out of range");

endmodule
`default_nettype wire

// ===== rtl/spbe_front.sv =====
// Front end: per-bin peak tracking and band sum-of-squares; pushes a snapshot on last bin.
// Depends on spbe_pkg.
`default_nettype none
module spbe_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire spbe_pkg::cfg_t   cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire spbe_pkg::in_item_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output spbe_pkg::snap_t       q_data
);

  logic [spbe_pkg::BinBits-1:0]   bin_r, bidx_r, bidx_nxt, start;
  logic [spbe_pkg::LevelBits-1:0] best_r, left_r, right_r, prior_r;
  logic [spbe_pkg::LevelBits-1:0] best_nxt, left_nxt, right_nxt, m;
  logic                           rp_r, take, found, accept;
  logic [2*spbe_pkg::LevelBits-1:0] sq;
  logic [spbe_pkg::NumBands-1:0][spbe_pkg::SumBits-1:0] sum_r, sum_nxt;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign m        = in_data.magnitude;
  assign start    = (cfg.search_start_bin == '0) ? spbe_pkg::BinBits'(1) : cfg.search_start_bin;
  assign take     = (bin_r == start) || ((bin_r > start) && (m > best_r));
  assign found    = bin_r >= start;
  assign sq       = m * m;

  always_comb begin
    best_nxt  = take ? m : best_r;
    bidx_nxt  = take ? bin_r : bidx_r;
    left_nxt  = take ? prior_r : left_r;
    right_nxt = rp_r ? m : right_r;
    for (int k = 0; k < spbe_pkg::NumBands; k++) begin
      logic [spbe_pkg::BinBits-1:0] lo;
      logic [spbe_pkg::SumBits:0]   s;
      lo = (cfg.band_low[k] == '0) ? spbe_pkg::BinBits'(1) : cfg.band_low[k];
      s  = {1'b0, sum_r[k]} + {{(spbe_pkg::SumBits+1-2*spbe_pkg::LevelBits){1'b0}}, sq};
      if (bin_r >= lo && bin_r <= cfg.band_high[k]) begin
        sum_nxt[k] = s[spbe_pkg::SumBits] ? spbe_pkg::SumMax : s[spbe_pkg::SumBits-1:0];
      end else begin
        sum_nxt[k] = sum_r[k];
      end
    end
  end

  always_comb begin
    q_push             = accept && in_data.last_bin;
    q_data.peak_index  = found ? bidx_nxt : '0;
    q_data.peak_valid  = found && (best_nxt >= cfg.min_peak_level);
    q_data.do_offset   = found && (best_nxt >= cfg.min_peak_level) && !take && (bidx_nxt != '0);
    q_data.left_level  = left_nxt;
    q_data.best_level  = best_nxt;
    q_data.right_level = right_nxt;
    q_data.sums        = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.last_bin)) begin
      bin_r   <= '0;
      bidx_r  <= '0;
      best_r  <= '0;
      left_r  <= '0;
      right_r <= '0;
      prior_r <= '0;
      rp_r    <= 1'b0;
      sum_r   <= '0;
    end else if (accept) begin
      bin_r   <= bin_r + spbe_pkg::BinBits'(1);  // wraps at 2048 bins
      bidx_r  <= bidx_nxt;
      best_r  <= best_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      prior_r <= m;
      rp_r    <= take;
      sum_r   <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spbe_fifo.sv =====
// Two-entry snapshot queue between front and back.
// Depends on spbe_pkg.
`default_nettype none
module spbe_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire spbe_pkg::snap_t push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output spbe_pkg::snap_t      pop_data
);

  spbe_pkg::snap_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spbe_back.sv =====
// Back end: optional bit-serial offset divide, then three digit-by-digit square roots.
// Depends on spbe_pkg.
`default_nettype none
module spbe_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire spbe_pkg::snap_t  q_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spbe_pkg::out_item_t   out_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_HOLD} state_t;

  state_t                state_r;
  spbe_pkg::snap_t       snap_r;
  logic [40:0]           rem_r;
  logic [25:0]           d_r;
  logic [15:0]           q_r;
  logic [3:0]            dcnt_r;
  logic                  neg_r;
  logic [59:0]           sval_r;
  logic [33:0]           srem_r;
  logic [29:0]           root_r;
  logic [4:0]            scnt_r;
  logic [1:0]            band_r;
  logic [2:0][29:0]      en_r;
  logic                  out_valid_r;
  spbe_pkg::out_item_t   out_data_r;

  // load-time operands
  logic [23:0] a, b, g, mag;
  logic [24:0] s2, b2, ud;
  logic [39:0] n_load;
  logic [41:0] dtrial;
  logic [33:0] srem2;
  logic [33:0] strial;
  logic [15:0] q_fin;

  assign a      = q_data.left_level;
  assign b      = q_data.best_level;
  assign g      = q_data.right_level;
  assign mag    = (a >= g) ? (a - g) : (g - a);
  assign s2     = {1'b0, a} + {1'b0, g};
  assign b2     = {b, 1'b0};
  assign ud     = (s2 >= b2) ? (s2 - b2) : (b2 - s2);
  assign n_load = {1'b0, mag, 15'd0} + {15'd0, ud};
  assign dtrial = {16'd0, d_r} << dcnt_r;
  assign srem2  = {srem_r[31:0], sval_r[59:58]};
  assign strial = {2'b00, root_r, 2'b01};
  assign q_fin  = (q_r > spbe_pkg::HalfBin) ? spbe_pkg::HalfBin : q_r;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            snap_r <= q_data;
            rem_r  <= {1'b0, n_load};
            d_r    <= {ud, 1'b0};
            q_r    <= '0;
            dcnt_r <= 4'd15;
            neg_r  <= (a < g) != (s2 < b2);
            if (q_data.do_offset && (s2 != b2)) begin
              state_r <= S_DIV;
            end else begin
              sval_r  <= {1'b0, q_data.sums[0]};
              srem_r  <= '0;
              root_r  <= '0;
              scnt_r  <= '0;
              band_r  <= '0;
              state_r <= S_SQRT;
            end
          end
        end
        S_DIV: begin
          if ({1'b0, rem_r} >= dtrial) begin
            rem_r <= rem_r - dtrial[40:0];
            q_r   <= q_r | (16'd1 << dcnt_r);
          end
          // quotient at or above 2^15 saturates
          if (dcnt_r == 4'd0 || (dcnt_r == 4'd15 && {1'b0, rem_r} >= dtrial)) begin
            if (dcnt_r == 4'd15) q_r <= spbe_pkg::HalfBin;
            sval_r  <= {1'b0, snap_r.sums[0]};
            srem_r  <= '0;
            root_r  <= '0;
            scnt_r  <= '0;
            band_r  <= '0;
            state_r <= S_SQRT;
          end
          dcnt_r <= dcnt_r - 1'b1;
        end
        S_SQRT: begin
          logic [33:0] nrem;
          logic [29:0] nroot;
          if (srem2 >= strial) begin
            nrem  = srem2 - strial;
            nroot = {root_r[28:0], 1'b1};
          end else begin
            nrem  = srem2;
            nroot = {root_r[28:0], 1'b0};
          end
          sval_r <= {sval_r[57:0], 2'b00};
          if (scnt_r == 5'd29) begin
            en_r[band_r] <= nroot;
            srem_r <= '0;
            root_r <= '0;
            scnt_r <= '0;
            if (band_r == 2'd2) begin
              state_r <= S_HOLD;
            end else begin
              sval_r <= {1'b0, snap_r.sums[band_r + 2'd1]};
              band_r <= band_r + 2'd1;
            end
          end else begin
            srem_r <= nrem;
            root_r <= nroot;
            scnt_r <= scnt_r + 5'd1;
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.peak_index    <= snap_r.peak_index;
            out_data_r.peak_valid    <= snap_r.peak_valid;
            out_data_r.peak_offset   <= neg_r ? -q_fin : q_fin;
            out_data_r.band_a_energy <= en_r[0];
            out_data_r.band_b_energy <= en_r[1];
            out_data_r.band_c_energy <= en_r[2];
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_spectral_peak_band_energy_top.sv =====
// Self-checking testbench for spectral_peak_band_energy_top: random and directed spectra
// with random idling, results checked against a predictor in a scoreboard class.
// Depends on rtl/spbe_pkg.sv and rtl/spectral_peak_band_energy_top.sv.
`default_nettype none
module tb_spectral_peak_band_energy_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Keeps a copy of the config and the per-spectrum state; each accepted bin updates
  // the state and a last bin queues the result the block must produce.
  class peak_band_board;
    logic [spbe_pkg::BinBits-1:0]   start_bin;
    logic [spbe_pkg::LevelBits-1:0] min_level;
    logic [spbe_pkg::BinBits-1:0]   lo_bin[spbe_pkg::NumBands];
    logic [spbe_pkg::BinBits-1:0]   hi_bin[spbe_pkg::NumBands];

    int unsigned          bin_pos;
    bit [63:0]            best_mag, left_mag, right_mag, prev_mag;
    int unsigned          best_pos;
    bit                   need_right;
    bit [63:0]            energy_sum[spbe_pkg::NumBands];

    spbe_pkg::out_item_t  expected_results[$];
    int                   errors;

    function void clear_spectrum();
      bin_pos = 0;
      best_mag = 0; left_mag = 0; right_mag = 0; prev_mag = 0;
      best_pos = 0;
      need_right = 0;
      foreach (energy_sum[k]) energy_sum[k] = 0;
    endfunction

    function void reset_state();
      start_bin = 11'd9;
      min_level = 24'd16777;
      foreach (lo_bin[k]) begin
        lo_bin[k] = 11'd1;
        hi_bin[k] = 11'd0;
      end
      errors = 0;
      clear_spectrum();
    endfunction

    function void set_reg(logic [spbe_pkg::CfgIdxBits-1:0] idx,
                          logic [spbe_pkg::CfgDataBits-1:0] val);
      case (idx)
        spbe_pkg::RegStart:  start_bin = val[spbe_pkg::BinBits-1:0];
        spbe_pkg::RegMinLvl: min_level = val;
        spbe_pkg::RegALow:   lo_bin[0] = val[spbe_pkg::BinBits-1:0];
        spbe_pkg::RegAHigh:  hi_bin[0] = val[spbe_pkg::BinBits-1:0];
        spbe_pkg::RegBLow:   lo_bin[1] = val[spbe_pkg::BinBits-1:0];
        spbe_pkg::RegBHigh:  hi_bin[1] = val[spbe_pkg::BinBits-1:0];
        spbe_pkg::RegCLow:   lo_bin[2] = val[spbe_pkg::BinBits-1:0];
        spbe_pkg::RegCHigh:  hi_bin[2] = val[spbe_pkg::BinBits-1:0];
        default: ;
      endcase
    endfunction

    // floor(sqrt(v)), one result bit at a time from the top
    function bit [spbe_pkg::RootBits-1:0] floor_root(bit [63:0] v);
      bit [63:0] r, trial;
      r = 0;
      for (int b = spbe_pkg::RootBits - 1; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) r = trial;
      end
      return r[spbe_pkg::RootBits-1:0];
    endfunction

    // Vertex of the parabola through (left, peak, right), in 1/32768 bin, rounded half away
    function logic signed [spbe_pkg::OffBits-1:0] vertex_offset(bit [63:0] a, bit [63:0] b,
                                                                bit [63:0] g);
      longint num, den;
      longint unsigned un, ud, q;
      num = (longint'(a) - longint'(g)) * 16384;
      den = longint'(a) - 2 * longint'(b) + longint'(g);
      if (den == 0) return '0;
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = (2 * un + ud) / (2 * ud);
      if (q > 16384) q = 16384;
      return spbe_pkg::OffBits'(((num < 0) != (den < 0)) ? -longint'(q) : longint'(q));
    endfunction

    function void note_bin(spbe_pkg::in_item_t it);
      bit [63:0]   m, sq;
      int unsigned i, first, lo;
      bit          found, ok;
      spbe_pkg::out_item_t r;
      logic [spbe_pkg::RootBits-1:0] root[spbe_pkg::NumBands];
      m = it.magnitude;
      i = bin_pos;
      first = (start_bin == 0) ? 1 : start_bin;
      if (need_right) begin
        right_mag = m;
        need_right = 0;
      end
      if (i == first || (i > first && m > best_mag)) begin
        best_mag = m;
        best_pos = i;
        left_mag = prev_mag;
        need_right = 1;
      end
      for (int k = 0; k < spbe_pkg::NumBands; k++) begin
        lo = (lo_bin[k] == 0) ? 1 : lo_bin[k];
        if (i >= lo && i <= hi_bin[k]) begin
          sq = m * m;
          energy_sum[k] = (sq > spbe_pkg::SumMax - energy_sum[k]) ?
                          64'(spbe_pkg::SumMax) : energy_sum[k] + sq;
        end
      end
      prev_mag = m;
      bin_pos = (i + 1 >= 2048) ? 0 : i + 1;
      if (!it.last_bin) return;
      found = (i >= first);
      ok = found && (best_mag >= min_level);
      foreach (root[k]) root[k] = floor_root(energy_sum[k]);
      r.peak_index = found ? best_pos[spbe_pkg::BinBits-1:0] : '0;
      r.peak_offset = (ok && !need_right && best_pos > 0) ?
                      vertex_offset(left_mag, best_mag, right_mag) : '0;
      r.peak_valid = ok;
      r.band_a_energy = root[0];
      r.band_b_energy = root[1];
      r.band_c_energy = root[2];
      expected_results.push_back(r);
      clear_spectrum();
    endfunction

    function void check_result(spbe_pkg::out_item_t got);
      spbe_pkg::out_item_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (got.peak_index !== e.peak_index) begin
        $display("%0t: peak_index exp %0d got %0d", $time, e.peak_index, got.peak_index);
        errors++;
      end
      if (got.peak_offset !== e.peak_offset) begin
        $display("%0t: peak_offset exp %0d got %0d", $time, e.peak_offset, got.peak_offset);
        errors++;
      end
      if (got.peak_valid !== e.peak_valid) begin
        $display("%0t: peak_valid exp %0d got %0d", $time, e.peak_valid, got.peak_valid);
        errors++;
      end
      if (got.band_a_energy !== e.band_a_energy) begin
        $display("%0t: band_a_energy exp %0d got %0d", $time, e.band_a_energy,
                 got.band_a_energy);
        errors++;
      end
      if (got.band_b_energy !== e.band_b_energy) begin
        $display("%0t: band_b_energy exp %0d got %0d", $time, e.band_b_energy,
                 got.band_b_energy);
        errors++;
      end
      if (got.band_c_energy !== e.band_c_energy) begin
        $display("%0t: band_c_energy exp %0d got %0d", $time, e.band_c_energy,
                 got.band_c_energy);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  spbe_pkg::in_item_t               in_data;
  logic                             out_valid;
  logic                             out_ready;
  spbe_pkg::out_item_t              out_data;
  logic                             cfg_we;
  logic [spbe_pkg::CfgIdxBits-1:0]  cfg_index;
  logic [spbe_pkg::CfgDataBits-1:0] cfg_data;

  peak_band_board board;
  bit             quiet;      // when set, neither side idles
  int             items_sent;

  spectral_peak_band_energy_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("[spectral_peak_band_energy_top] ERROR");
    $finish;
  end

  // One bin: optional idle gap, then hold valid until the handshake.
  task automatic send_bin(logic [spbe_pkg::LevelBits-1:0] mag, logic last);
    int gap;
    spbe_pkg::in_item_t it;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.magnitude = mag;
    it.last_bin = last;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.note_bin(it);
    items_sent++;
  endtask

  // Wait for every queued result, then let the front drain before touching config.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_config(logic [spbe_pkg::CfgDataBits-1:0] vals[8]);
    for (int r = 0; r < 8; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= r[spbe_pkg::CfgIdxBits-1:0];
      cfg_data <= vals[r];
      @(posedge clk);
      board.set_reg(r[spbe_pkg::CfgIdxBits-1:0], vals[r]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [spbe_pkg::LevelBits-1:0] pick_level(int style, int pos,
                                                               int peak_at);
    case (style)
      0: return spbe_pkg::LevelBits'($urandom());
      1: return spbe_pkg::LevelBits'($urandom_range(0, 255));
      2: return $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'h0;
      default: begin
        // noise floor with one smooth peak, so the offset is meaningful
        int d;
        d = (pos > peak_at) ? pos - peak_at : peak_at - pos;
        if (d == 0) return spbe_pkg::LevelBits'($urandom_range(24'h400000, 24'hFFFFFF));
        if (d == 1) return spbe_pkg::LevelBits'($urandom_range(24'h100000, 24'h3FFFFF));
        return spbe_pkg::LevelBits'($urandom_range(0, 24'h00FFFF));
      end
    endcase
  endfunction

  // One spectrum of the given length with random content; always ends on a last bin.
  task automatic send_spectrum(int len);
    int style, peak_at;
    style = $urandom_range(0, 5);
    peak_at = $urandom_range(0, len - 1);
    for (int p = 0; p < len; p++)
      send_bin(pick_level(style, p, peak_at), p == len - 1);
  endtask

  task automatic random_config();
    logic [spbe_pkg::CfgDataBits-1:0] v[8];
    v[0] = spbe_pkg::CfgDataBits'($urandom_range(0, 24));
    v[1] = ($urandom_range(0, 2) == 0) ? spbe_pkg::CfgDataBits'($urandom()) :
                                         spbe_pkg::CfgDataBits'($urandom_range(0, 4096));
    for (int k = 0; k < 3; k++) begin
      v[2 + 2 * k] = spbe_pkg::CfgDataBits'($urandom_range(0, 20));
      v[3 + 2 * k] = spbe_pkg::CfgDataBits'($urandom_range(0, 30));
    end
    write_config(v);
  endtask

  // Directed spectra: normal peak, flat top, peak on last bin, start not reached, ties.
  task automatic directed_part();
    logic [spbe_pkg::CfgDataBits-1:0] v[8];
    v = '{24'd2, 24'd100, 24'd1, 24'd5, 24'd0, 24'd3, 24'd5, 24'd2};
    write_config(v);
    send_bin(24'd5, 0); send_bin(24'd10, 0); send_bin(24'hFFFFFF, 0);
    send_bin(24'd8, 0); send_bin(24'd0, 1);
    // flat spectrum: zero denominator
    send_bin(24'd7, 0); send_bin(24'd7, 0); send_bin(24'd7, 0); send_bin(24'd7, 1);
    // peak on the last bin, also below the minimum level
    send_bin(24'd1, 0); send_bin(24'd1, 0); send_bin(24'd50, 1);
    // single bin, search start never reached
    send_bin(24'd3, 1);
    // equal maxima: the first one wins
    send_bin(24'd0, 0); send_bin(24'd0, 0); send_bin(24'd9, 0); send_bin(24'd9, 0);
    send_bin(24'hFFFFFF, 0); send_bin(24'hFFFFFF, 0); send_bin(24'd1, 1);
  endtask

  initial begin
    logic [spbe_pkg::CfgDataBits-1:0] v[8];
    board = new();
    board.reset_state();
    quiet = 0;
    items_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: empty bands, start at 9
    repeat (5) send_spectrum($urandom_range(4, 24));
    wait_idle();
    directed_part();
    wait_idle();

    // extremes: start 0 acts as 1, no minimum, every band covers bins 1 to 2047.
    // One overlong all-max spectrum wraps the bin index and saturates the sums.
    v = '{24'd0, 24'd0, 24'd0, 24'd2047, 24'd0, 24'd2047, 24'd1, 24'd2047};
    write_config(v);
    quiet = 1;
    for (int p = 0; p < 2060; p++) send_bin(24'hFFFFFF, p == 2059);
    quiet = 0;
    repeat (3) send_spectrum($urandom_range(2, 30));
    wait_idle();

    // other extreme: start and minimum at the top, so the search is never reached
    v = '{24'd2047, 24'hFFFFFF, 24'd2047, 24'd2047, 24'd1, 24'd2047, 24'd2047, 24'd0};
    write_config(v);
    repeat (4) send_spectrum($urandom_range(1, 30));
    wait_idle();

    items_sent = 0;
    while (items_sent < 1400) begin
      random_config();
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        // sender holds off until the block has drained
        if ($urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (board.expected_results.size() != 0);
        end
        send_spectrum($urandom_range(1, 40));
      end
      wait_idle();
    end

    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("[spectral_peak_band_energy_top] OK");
    end else begin
      $display("[spectral_peak_band_energy_top] ERROR");
    end
    $finish;
  end

  // Result side: random stall per item, ready stays high when no stall is drawn.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(out_data);
    end
  end
endmodule
`default_nettype wire

// ===== spectral_peak_band_energy_top.f =====
rtl/spbe_pkg.sv
rtl/spbe_front.sv
rtl/spbe_fifo.sv
rtl/spbe_back.sv
rtl/spectral_peak_band_energy_top.sv
sim/tb_spectral_peak_band_energy_top.sv
